@@ rtl/aa_capsule_line_blend_top_defines.svh @@
// ---------------------------------------------------------------------------
// aa_capsule_line_blend_top_defines
// assertion macros used by the capsule line blend rtl
// ---------------------------------------------------------------------------
`ifndef AA_CAPSULE_LINE_BLEND_TOP_DEFINES_SVH
`define AA_CAPSULE_LINE_BLEND_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define AA_CLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define AA_CLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/aa_clb_pkg.sv @@
// ---------------------------------------------------------------------------
// aa_clb_pkg
// shared types and constants of the capsule line blend pipeline
// ---------------------------------------------------------------------------
package aa_clb_pkg;

  localparam int COORD_W = 17;
  localparam int PIX_W   = 12;
  localparam int ARGB_W  = 32;
  localparam int T_W     = 16;
  localparam logic [T_W:0] T_ONE = {1'b1, {T_W{1'b0}}};

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_W   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SURF_W   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SURF_H   = 4'd7;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [11:0]        half_width;
    logic [ARGB_W-1:0]  line_color;
    logic [12:0]        surface_width;
    logic [12:0]        surface_height;
  } cfg_t;

endpackage

@@ rtl/aa_capsule_line_blend_top.sv @@
// ---------------------------------------------------------------------------
// aa_capsule_line_blend_top
// antialiased capsule line shader with source-over blend; without stalls, one pixel a cycle
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one pixel per beat: column, row and the framebuffer value.
//   m_axis returns one beat per pixel in order: the blended value in tdata
//   and the write flag in tuser; tdata equals the input value when not set.
//   cfg writes segment end points, half width, colour and surface size by
//   index; cfg_ready is always high. write only while no pixel is in flight.
// pipeline and throughput:
//   stages with default parameters: 3 geometry, 9 divider, 4 distance,
//   14 square root and 4 blend; one pixel per cycle when m_axis_tready
//   does not stall, set by the fully pipelined divider and square root.
// reset:
//   clears all stage valid bits and loads the register reset values.
// stall:
//   when m_axis_tready is low with a beat waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module aa_capsule_line_blend_top import aa_clb_pkg::*; #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [55:0]          s_axis_tdata,   // pix_x[11:0], pix_y[23:12], dst_pixel[55:24]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // out_pixel[31:0]
  output logic [0:0]           m_axis_tuser,   // write_flag[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_data
);

  localparam int M      = (PIX_W + FRAC_BITS > 16) ? PIX_W + FRAC_BITS : 16;
  localparam int WW     = M + 2;
  localparam int LW     = 2 * WW;
  localparam int DW     = WW + 9;
  localparam int RW     = DW + (DW % 2);
  localparam int NW     = 2 * RW;
  localparam int SIDE_W = 2 * WW + ARGB_W + 1;
  localparam int SQ_SW  = ARGB_W + 1;
  localparam logic [12:0] SURF_RST = 13'((MAX_DIM > 8191) ? 8191 : MAX_DIM);

  cfg_t cfg;
  logic en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x        <= '0;
      cfg.start_y        <= '0;
      cfg.end_x          <= '0;
      cfg.end_y          <= '0;
      cfg.half_width     <= '0;
      cfg.line_color     <= '0;
      cfg.surface_width  <= SURF_RST;
      cfg.surface_height <= SURF_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_START_X: cfg.start_x        <= cfg_data[COORD_W-1:0];
        CFG_START_Y: cfg.start_y        <= cfg_data[COORD_W-1:0];
        CFG_END_X:   cfg.end_x          <= cfg_data[COORD_W-1:0];
        CFG_END_Y:   cfg.end_y          <= cfg_data[COORD_W-1:0];
        CFG_HALF_W:  cfg.half_width     <= cfg_data[11:0];
        CFG_COLOR:   cfg.line_color     <= cfg_data;
        CFG_SURF_W:  cfg.surface_width  <= cfg_data[12:0];
        CFG_SURF_H:  cfg.surface_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = en;

  // geometry front end
  logic                 g_valid, g_draw;
  logic signed [LW-1:0] g_dot;
  logic [LW-1:0]        g_len2;
  logic signed [WW-1:0] g_wx, g_wy;
  logic [ARGB_W-1:0]    g_dst;

  aa_clb_geom #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM),
    .WW        (WW),
    .LW        (LW)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .pix_x     (s_axis_tdata[11:0]),
    .pix_y     (s_axis_tdata[23:12]),
    .dst_pixel (s_axis_tdata[55:24]),
    .out_valid (g_valid),
    .dot       (g_dot),
    .len2      (g_len2),
    .wx        (g_wx),
    .wy        (g_wy),
    .dst       (g_dst),
    .draw      (g_draw)
  );

  // projection parameter
  logic              d_valid;
  logic [T_W:0]      d_t;
  logic [SIDE_W-1:0] d_side;

  aa_clb_div #(
    .LW     (LW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .dot       (g_dot),
    .len2      (g_len2),
    .side_in   ({g_draw, g_dst, g_wy, g_wx}),
    .out_valid (d_valid),
    .t         (d_t),
    .side_out  (d_side)
  );

  // squared distance
  logic              q_valid, q_draw;
  logic [NW-1:0]     q_n;
  logic [ARGB_W-1:0] q_dst;

  aa_clb_dist #(
    .WW (WW),
    .DW (DW),
    .NW (NW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .t         (d_t),
    .wx        ($signed(d_side[WW-1:0])),
    .wy        ($signed(d_side[2*WW-1:WW])),
    .dst_in    (d_side[2*WW +: ARGB_W]),
    .draw_in   (d_side[SIDE_W-1]),
    .out_valid (q_valid),
    .n         (q_n),
    .dst       (q_dst),
    .draw      (q_draw)
  );

  // distance
  logic             r_valid;
  logic [RW-1:0]    r_root;
  logic [SQ_SW-1:0] r_side;

  aa_clb_sqrt #(
    .RW     (RW),
    .SIDE_W (SQ_SW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .n         (q_n),
    .side_in   ({q_draw, q_dst}),
    .out_valid (r_valid),
    .root      (r_root),
    .side_out  (r_side)
  );

  aa_clb_blend #(
    .RW        (RW),
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (r_valid),
    .root       (r_root),
    .dst_in     (r_side[ARGB_W-1:0]),
    .draw_in    (r_side[SQ_SW-1]),
    .en         (en),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pixel  (m_axis_tdata),
    .write_flag (m_axis_tuser[0])
  );

endmodule

@@ rtl/aa_clb_geom.sv @@
// ---------------------------------------------------------------------------
// aa_clb_geom
// pixel centre offsets, dot product and squared segment length (3 stages)
// ---------------------------------------------------------------------------
module aa_clb_geom import aa_clb_pkg::*; #(
  parameter int FRAC_BITS = 4,
  parameter int MAX_DIM   = 4096,
  parameter int WW        = 18,
  parameter int LW        = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  logic [PIX_W-1:0]     pix_x,
  input  logic [PIX_W-1:0]     pix_y,
  input  logic [ARGB_W-1:0]    dst_pixel,
  output logic                 out_valid,
  output logic signed [LW-1:0] dot,
  output logic [LW-1:0]        len2,
  output logic signed [WW-1:0] wx,
  output logic signed [WW-1:0] wy,
  output logic [ARGB_W-1:0]    dst,
  output logic                 draw
);

  localparam int PADW = WW - PIX_W - FRAC_BITS;

  logic signed [WW-1:0] sx, sy, ex, ey, cx, cy;
  logic                 on_surf;

  logic                 v1, v2;
  logic signed [WW-1:0] wx1, wy1, vx1, vy1, wx2, wy2;
  logic [ARGB_W-1:0]    dst1, dst2;
  logic                 draw1, draw2;
  logic signed [LW-1:0] pxv, pyv, qxv, qyv;

  assign sx = $signed({{(WW-COORD_W){cfg.start_x[COORD_W-1]}}, cfg.start_x});
  assign sy = $signed({{(WW-COORD_W){cfg.start_y[COORD_W-1]}}, cfg.start_y});
  assign ex = $signed({{(WW-COORD_W){cfg.end_x[COORD_W-1]}}, cfg.end_x});
  assign ey = $signed({{(WW-COORD_W){cfg.end_y[COORD_W-1]}}, cfg.end_y});

  // pixel centre sits half a pixel into the cell
  assign cx = $signed({{PADW{1'b0}}, pix_x, 1'b1, {(FRAC_BITS-1){1'b0}}});
  assign cy = $signed({{PADW{1'b0}}, pix_y, 1'b1, {(FRAC_BITS-1){1'b0}}});

  assign on_surf = ({1'b0, pix_x} < cfg.surface_width) &&
                   ({1'b0, pix_y} < cfg.surface_height) &&
                   (32'(pix_x) < MAX_DIM) && (32'(pix_y) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx1   <= cx - sx;
      wy1   <= cy - sy;
      vx1   <= ex - sx;
      vy1   <= ey - sy;
      dst1  <= dst_pixel;
      draw1 <= (cfg.half_width != 12'd0) && on_surf;

      pxv   <= wx1 * vx1;
      pyv   <= wy1 * vy1;
      qxv   <= vx1 * vx1;
      qyv   <= vy1 * vy1;
      wx2   <= wx1;
      wy2   <= wy1;
      dst2  <= dst1;
      draw2 <= draw1;

      dot   <= pxv + pyv;
      len2  <= LW'(qxv + qyv);
      wx    <= wx2;
      wy    <= wy2;
      dst   <= dst2;
      draw  <= draw2;
    end
  end

endmodule

@@ rtl/aa_clb_div.sv @@
// ---------------------------------------------------------------------------
// aa_clb_div
// pipelined restoring divider for the projection parameter t, two bits a stage
// ---------------------------------------------------------------------------
module aa_clb_div import aa_clb_pkg::*; #(
  parameter int LW     = 36,
  parameter int SIDE_W = 69
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [LW-1:0] dot,
  input  logic [LW-1:0]        len2,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [T_W:0]         t,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int NST = T_W / 2;
  localparam logic [1:0] MD_DIV  = 2'd0;
  localparam logic [1:0] MD_ZERO = 2'd1;
  localparam logic [1:0] MD_ONE  = 2'd2;

  logic              vld [NST];
  logic [LW-1:0]     rem [NST];
  logic [LW-1:0]     dvs [NST];
  logic [T_W-1:0]    quo [NST];
  logic [1:0]        md  [NST];
  logic [SIDE_W-1:0] sd  [NST];

  function automatic logic [LW:0] div_step(input logic [LW-1:0] r, input logic [LW-1:0] d);
    logic [LW:0] r2;
    logic [LW:0] df;
    r2 = {r, 1'b0};
    df = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      return {1'b1, df[LW-1:0]};
    end else begin
      return {1'b0, r2[LW-1:0]};
    end
  endfunction

  for (genvar i = 0; i < NST; i++) begin : g_st
    logic              v_in;
    logic [LW-1:0]     r_in, d_in;
    logic [T_W-1:0]    q_in;
    logic [1:0]        m_in;
    logic [SIDE_W-1:0] s_in;
    logic [LW:0]       s1, s2;

    if (i == 0) begin : g_first
      logic is_zero, is_one;
      always_comb begin
        is_zero = (len2 == '0) || dot[LW-1] || (dot == '0);
        is_one  = !is_zero && ($signed(dot) >= $signed(len2));
        if (is_zero) begin
          m_in = MD_ZERO;
        end else if (is_one) begin
          m_in = MD_ONE;
        end else begin
          m_in = MD_DIV;
        end
        r_in = (m_in == MD_DIV) ? dot : '0;
        d_in = len2;
        q_in = '0;
        v_in = in_valid;
        s_in = side_in;
      end
    end else begin : g_next
      assign v_in = vld[i-1];
      assign r_in = rem[i-1];
      assign d_in = dvs[i-1];
      assign q_in = quo[i-1];
      assign m_in = md[i-1];
      assign s_in = sd[i-1];
    end

    assign s1 = div_step(r_in, d_in);
    assign s2 = div_step(s1[LW-1:0], d_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= s2[LW-1:0];
        dvs[i] <= d_in;
        quo[i] <= {q_in[T_W-3:0], s1[LW], s2[LW]};
        md[i]  <= m_in;
        sd[i]  <= s_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (md[NST-1])
        MD_ONE:  t <= T_ONE;
        MD_ZERO: t <= '0;
        default: t <= {1'b0, quo[NST-1]};
      endcase
      side_out <= sd[NST-1];
    end
  end

endmodule

@@ rtl/aa_clb_dist.sv @@
// ---------------------------------------------------------------------------
// aa_clb_dist
// offset from the nearest segment point and its squared length (4 stages)
// ---------------------------------------------------------------------------
module aa_clb_dist import aa_clb_pkg::*; #(
  parameter int WW = 18,
  parameter int DW = 27,
  parameter int NW = 56
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  logic [T_W:0]         t,
  input  logic signed [WW-1:0] wx,
  input  logic signed [WW-1:0] wy,
  input  logic [ARGB_W-1:0]    dst_in,
  input  logic                 draw_in,
  output logic                 out_valid,
  output logic [NW-1:0]        n,
  output logic [ARGB_W-1:0]    dst,
  output logic                 draw
);

  localparam int PW = WW + T_W + 2;

  logic signed [WW-1:0] sx, sy, vx, vy;
  logic                 v1, v2, v3;
  logic signed [PW-1:0] tx, ty, rx, ry, hx, hy;
  logic signed [WW-1:0] wx1, wy1;
  logic signed [DW-1:0] wxs, wys, dx, dy;
  logic [2*DW-1:0]      sqx, sqy;
  logic [ARGB_W-1:0]    dst1, dst2, dst3;
  logic                 draw1, draw2, draw3;

  assign sx = $signed({{(WW-COORD_W){cfg.start_x[COORD_W-1]}}, cfg.start_x});
  assign sy = $signed({{(WW-COORD_W){cfg.start_y[COORD_W-1]}}, cfg.start_y});
  assign vx = $signed({{(WW-COORD_W){cfg.end_x[COORD_W-1]}}, cfg.end_x}) - sx;
  assign vy = $signed({{(WW-COORD_W){cfg.end_y[COORD_W-1]}}, cfg.end_y}) - sy;

  // round t*v to the offset grid, floor on negatives
  assign rx  = tx + PW'(128);
  assign ry  = ty + PW'(128);
  assign hx  = rx >>> 8;
  assign hy  = ry >>> 8;
  assign wxs = $signed({wx1[WW-1], wx1, 8'h00});
  assign wys = $signed({wy1[WW-1], wy1, 8'h00});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx    <= $signed({1'b0, t}) * vx;
      ty    <= $signed({1'b0, t}) * vy;
      wx1   <= wx;
      wy1   <= wy;
      dst1  <= dst_in;
      draw1 <= draw_in;

      dx    <= wxs - $signed(hx[DW-1:0]);
      dy    <= wys - $signed(hy[DW-1:0]);
      dst2  <= dst1;
      draw2 <= draw1;

      sqx   <= dx * dx;
      sqy   <= dy * dy;
      dst3  <= dst2;
      draw3 <= draw2;

      n     <= {{(NW-2*DW){1'b0}}, sqx} + {{(NW-2*DW){1'b0}}, sqy};
      dst   <= dst3;
      draw  <= draw3;
    end
  end

endmodule

@@ rtl/aa_clb_sqrt.sv @@
// ---------------------------------------------------------------------------
// aa_clb_sqrt
// pipelined integer square root, two result bits a stage
// ---------------------------------------------------------------------------
module aa_clb_sqrt #(
  parameter int RW     = 28,
  parameter int SIDE_W = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   n,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [RW-1:0]     root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int NW  = 2 * RW;
  localparam int NST = RW / 2;
  localparam int SW  = NW + RW + 1 + RW;

  logic              vld [NST];
  logic [NW-1:0]     rad [NST];
  logic [RW:0]       rem [NST];
  logic [RW-1:0]     rt  [NST];
  logic [SIDE_W-1:0] sd  [NST];

  // one digit: bring down two radicand bits, try (root << 2) | 1
  function automatic logic [SW-1:0] sq_step(input logic [NW-1:0] a, input logic [RW:0] r,
                                            input logic [RW-1:0] q);
    logic [RW+2:0] r2;
    logic [RW+2:0] trial;
    logic [RW+2:0] df;
    r2    = {r, a[NW-1:NW-2]};
    trial = {1'b0, q, 2'b01};
    df    = r2 - trial;
    if (r2 >= trial) begin
      return {a << 2, df[RW:0], q[RW-2:0], 1'b1};
    end else begin
      return {a << 2, r2[RW:0], q[RW-2:0], 1'b0};
    end
  endfunction

  for (genvar i = 0; i < NST; i++) begin : g_st
    logic              v_in;
    logic [NW-1:0]     a_in;
    logic [RW:0]       r_in;
    logic [RW-1:0]     q_in;
    logic [SIDE_W-1:0] s_in;
    logic [SW-1:0]     s1, s2;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign a_in = n;
      assign r_in = '0;
      assign q_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign a_in = rad[i-1];
      assign r_in = rem[i-1];
      assign q_in = rt[i-1];
      assign s_in = sd[i-1];
    end

    assign s1 = sq_step(a_in, r_in, q_in);
    assign s2 = sq_step(s1[SW-1 -: NW], s1[2*RW:RW], s1[RW-1:0]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i] <= s2[SW-1 -: NW];
        rem[i] <= s2[2*RW:RW];
        rt[i]  <= s2[RW-1:0];
        sd[i]  <= s_in;
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign root      = rt[NST-1];
  assign side_out  = sd[NST-1];

endmodule

@@ rtl/aa_clb_blend.sv @@
// ---------------------------------------------------------------------------
// aa_clb_blend
// coverage to alpha, source-over blend and the output register (4 stages)
// ---------------------------------------------------------------------------
`include "aa_capsule_line_blend_top_defines.svh"

module aa_clb_blend import aa_clb_pkg::*; #(
  parameter int RW        = 28,
  parameter int FRAC_BITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  input  logic [RW-1:0]     root,
  input  logic [ARGB_W-1:0] dst_in,
  input  logic              draw_in,
  output logic              en,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ARGB_W-1:0] out_pixel,
  output logic              write_flag
);

  localparam int CW     = RW + 2;
  localparam int HALF_E = 1 << (FRAC_BITS + 7);
  localparam int HALF_F = 1 << (FRAC_BITS - 1);

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, x} + 17'd1;
    s2 = s1 + {8'h00, s1[16:8]};
    return s2[15:8];
  endfunction

  logic signed [CW-1:0] cov, c8;
  logic                 cov_pos;
  logic [8:0]           cov8_n;
  logic [16:0]          am;
  logic [7:0]           inv;

  logic                 b1_valid, b2_valid, b3_valid;
  logic                 b1_live, b2_live, b3_live;
  logic [8:0]           b1_cov8;
  logic [7:0]           b2_a, b3_a;
  logic [ARGB_W-1:0]    b1_dst, b2_dst, b3_dst;
  logic [15:0]          b3_r, b3_g, b3_b, b3_da;

  assign en = !out_valid || out_ready;

  assign cov     = $signed(CW'({cfg.half_width, 8'h00})) + $signed(CW'(HALF_E))
                   - $signed({2'b00, root});
  assign cov_pos = !cov[CW-1] && (cov != '0);
  assign c8      = (cov + $signed(CW'(HALF_F))) >>> FRAC_BITS;
  assign cov8_n  = (c8[CW-2:0] > (CW-1)'(256)) ? 9'd256 : c8[8:0];

  assign am  = 17'(cfg.line_color[31:24]) * 17'(b1_cov8) + 17'd128;
  assign inv = 8'hFF - b2_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= in_valid;
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      out_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_cov8 <= cov8_n;
      b1_live <= draw_in && cov_pos;
      b1_dst  <= dst_in;

      b2_a    <= am[15:8];
      b2_live <= b1_live;
      b2_dst  <= b1_dst;

      b3_r    <= 16'(cfg.line_color[23:16]) * 16'(b2_a) + 16'(b2_dst[23:16]) * 16'(inv);
      b3_g    <= 16'(cfg.line_color[15:8]) * 16'(b2_a) + 16'(b2_dst[15:8]) * 16'(inv);
      b3_b    <= 16'(cfg.line_color[7:0]) * 16'(b2_a) + 16'(b2_dst[7:0]) * 16'(inv);
      b3_da   <= 16'(b2_dst[31:24]) * 16'(inv);
      b3_a    <= b2_a;
      b3_live <= b2_live;
      b3_dst  <= b2_dst;

      if (!b3_live || (b3_a == 8'h00)) begin
        out_pixel  <= b3_dst;
        write_flag <= 1'b0;
      end else if (b3_a == 8'hFF) begin
        out_pixel  <= {8'hFF, cfg.line_color[23:0]};
        write_flag <= 1'b1;
      end else begin
        out_pixel  <= {b3_a + div255(b3_da), div255(b3_r), div255(b3_g), div255(b3_b)};
        write_flag <= 1'b1;
      end
    end
  end

  `AA_CLB_ASSERT_NOW(a_flag_alpha, out_valid && write_flag, out_pixel[31:24] != 8'h00, "written pixel has zero alpha")
  `AA_CLB_ASSERT_NEXT(a_opaque, b3_valid && en && b3_live && (b3_a == 8'hFF), write_flag && (out_pixel[31:24] == 8'hFF), "opaque source not written as opaque")
  `AA_CLB_ASSERT_NEXT(a_skip, b3_valid && en && (!b3_live || (b3_a == 8'h00)), !write_flag && (out_pixel == $past(b3_dst)), "skipped pixel not passed through")
  `AA_CLB_ASSERT_NEXT(a_hold, b3_valid && !en, b3_valid && $stable(b3_a) && $stable(b3_dst), "blend stage moved during stall")

endmodule
